// ----- rtl/hcb_pkg.sv -----
// shared types and constants for the huffman code builder
package hcb_pkg;

  // one input item
  typedef struct packed {
    logic [15:0] weight;
    logic        last_symbol;
  } hcb_in_t;

  // one result item
  typedef struct packed {
    logic [3:0]  symbol_index;
    logic [14:0] code_bits;
    logic [3:0]  code_length;
    logic        last_code;
  } hcb_out_t;

  localparam int unsigned WeightW = 20;
  localparam int unsigned CodeW   = 15;
  localparam int unsigned LenW    = 4;
  localparam int unsigned IdxW    = 4;

  // back end sequencer states
  typedef enum logic [2:0] {
    BE_IDLE,
    BE_SCAN,
    BE_MERGE,
    BE_WALK,
    BE_EMIT,
    BE_CLEAR
  } be_state_e;

  // queue entry between front and back
  typedef struct packed {
    logic [15:0] weight;
    logic        close;
  } hcb_q_t;

endpackage

// ----- rtl/hcb_front.sv -----
// front end: takes weights, marks the item that closes the set, two-entry queue
module hcb_front import hcb_pkg::*; #(
  parameter int unsigned MaxSymbols = 16,
  parameter int unsigned CntW       = 5
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  hcb_in_t in_i,
  output logic    busy_o,
  output logic    q_valid_o,
  output hcb_q_t  q_data_o,
  input  logic    q_pop_i
);

  logic [CntW-1:0] cnt_q, cnt_d;
  hcb_q_t          q_mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      fill_q;
  logic            push;
  hcb_q_t          entry;

  assign busy_o = (fill_q == 2'd2);
  assign push   = start_i && !busy_o;

  // classify: last flag or full set closes
  always_comb begin
    cnt_d = cnt_q + CntW'(1);
    entry.weight = in_i.weight;
    entry.close  = in_i.last_symbol || (cnt_d == CntW'(MaxSymbols));
    if (entry.close) begin
      cnt_d = '0;
    end
  end

  // symbol counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (push) begin
      cnt_q <= cnt_d;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= entry;
  end

  assign q_valid_o = (fill_q != 2'd0);
  assign q_data_o  = q_mem_q[rd_ptr_q];

endmodule

// ----- rtl/hcb_back.sv -----
// back end: stores leaves, builds the tree by serial minimum scans, walks codes
module hcb_back import hcb_pkg::*; #(
  parameter int unsigned MaxSymbols = 16,
  parameter int unsigned NodeW      = 6
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  hcb_q_t   q_data_i,
  output logic     q_pop_o,
  output logic     res_valid_o,
  output hcb_out_t res_o
);

  localparam int unsigned Slots = 2 * MaxSymbols;

  be_state_e state_q, state_d;

  logic [WeightW-1:0] wgt_q [Slots];
  logic [NodeW-1:0]   par_q [Slots];
  logic [NodeW-1:0]   lft_q [Slots];
  logic [Slots-1:0]   has_par_q;

  logic [NodeW-1:0] n_q;       // leaves stored so far
  logic [NodeW-1:0] k_q;       // node being built
  logic [NodeW-1:0] scan_q;    // scan position
  logic [NodeW-1:0] a_q, b_q;  // smallest and second smallest
  logic             a_ok_q, b_ok_q;
  logic [NodeW-1:0] s_q;       // symbol being walked
  logic [NodeW-1:0] c_q;       // current walk node
  logic [CodeW-1:0] code_q;
  logic [LenW-1:0]  len_q;
  logic [NodeW-1:0] clr_q;
  logic             res_valid_q;
  hcb_out_t         res_q;

  logic scan_take, scan_end, walk_end;
  logic [NodeW-1:0] par_c;

  assign q_pop_o   = (state_q == BE_IDLE) && q_valid_i;
  assign scan_end  = (scan_q == k_q - NodeW'(1));
  assign par_c     = par_q[c_q[NodeW-1:0]];
  assign walk_end  = !has_par_q[c_q];
  assign scan_take = !has_par_q[scan_q];

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BE_IDLE:  if (q_pop_o && q_data_i.close) begin
        state_d = (n_q == '0) ? BE_WALK : BE_SCAN;
      end
      BE_SCAN:  if (scan_end) state_d = BE_MERGE;
      BE_MERGE: state_d = (k_q == NodeW'(2) * n_q - NodeW'(2)) ? BE_WALK : BE_SCAN;
      BE_WALK:  if (walk_end) state_d = BE_EMIT;
      BE_EMIT:  state_d = (s_q == n_q - NodeW'(1)) ? BE_CLEAR : BE_WALK;
      BE_CLEAR: if (clr_q == NodeW'(Slots - 1)) state_d = BE_IDLE;
      default:  state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BE_IDLE;
    else         state_q <= state_d;
  end

  // control registers and link flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0; k_q <= '0; scan_q <= '0; a_ok_q <= 1'b0; b_ok_q <= 1'b0;
      s_q <= '0; c_q <= '0; clr_q <= '0; has_par_q <= '0; res_valid_q <= 1'b0;
      len_q <= '0; code_q <= '0; a_q <= '0; b_q <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        BE_IDLE: begin
          if (q_pop_o) begin
            n_q <= n_q + NodeW'(1);
            has_par_q[n_q] <= 1'b0;
            k_q    <= n_q + NodeW'(1);
            scan_q <= '0;
            a_ok_q <= 1'b0; b_ok_q <= 1'b0;
            s_q <= '0; c_q <= '0; len_q <= '0; code_q <= '0;
          end
        end
        // one node per cycle, keep two smallest, lowest index wins ties
        BE_SCAN: begin
          if (scan_take) begin
            if (!a_ok_q || wgt_q[scan_q] < wgt_q[a_q]) begin
              b_q <= a_q; b_ok_q <= a_ok_q;
              a_q <= scan_q; a_ok_q <= 1'b1;
            end else if (!b_ok_q || wgt_q[scan_q] < wgt_q[b_q]) begin
              b_q <= scan_q; b_ok_q <= 1'b1;
            end
          end
          scan_q <= scan_q + NodeW'(1);
        end
        BE_MERGE: begin
          has_par_q[a_q] <= 1'b1;
          has_par_q[b_q] <= 1'b1;
          has_par_q[k_q] <= 1'b0;
          k_q    <= k_q + NodeW'(1);
          scan_q <= '0;
          a_ok_q <= 1'b0; b_ok_q <= 1'b0;
        end
        // climb one level per cycle
        BE_WALK: begin
          if (!walk_end) begin
            if (lft_q[par_c] != c_q) code_q <= code_q | (CodeW'(1) << len_q);
            len_q <= len_q + LenW'(1);
            c_q   <= par_c;
          end
        end
        BE_EMIT: begin
          res_valid_q <= 1'b1;
          s_q <= s_q + NodeW'(1);
          c_q <= s_q + NodeW'(1);
          len_q <= '0; code_q <= '0;
          clr_q <= '0;
        end
        BE_CLEAR: begin
          has_par_q[clr_q] <= 1'b0;
          clr_q <= clr_q + NodeW'(1);
          n_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == BE_EMIT) begin
      res_q.symbol_index <= s_q[IdxW-1:0];
      res_q.code_bits    <= code_q;
      res_q.code_length  <= len_q;
      res_q.last_code    <= (s_q == n_q - NodeW'(1));
    end
  end

  // node storage
  always_ff @(posedge clk_i) begin
    if (state_q == BE_IDLE && q_pop_o) begin
      wgt_q[n_q] <= {{(WeightW-16){1'b0}}, q_data_i.weight};
    end
    if (state_q == BE_MERGE) begin
      wgt_q[k_q] <= wgt_q[a_q] + wgt_q[b_q];
      par_q[a_q] <= k_q;
      par_q[b_q] <= k_q;
      lft_q[k_q] <= a_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/huffman_code_builder.sv -----
// top level of the huffman code builder
// after the closing item: n-1 merges, each a serial scan of the built nodes then a merge step,
// then per symbol a walk up the tree and an emit, then a clear of all 2*MAX_SYMBOLS node slots
// open items are accepted while busy is low; set closes are bound by the serial scan
// reset: asynchronous active low, clears counters, queue and link flags
// results are strobed for one cycle; the receiver cannot stall
module huffman_code_builder import hcb_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  hcb_in_t  in_i,
  output logic     busy,
  output logic     valid_o,
  output hcb_out_t out_o
);

  localparam int unsigned NodeW = $clog2(2 * MAX_SYMBOLS);

  logic   q_valid, q_pop;
  hcb_q_t q_data;

  hcb_front #(.MaxSymbols(MAX_SYMBOLS), .CntW(NodeW)) u_front (
    .clk_i, .rst_ni, .start_i(start), .in_i, .busy_o(busy),
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  hcb_back #(.MaxSymbols(MAX_SYMBOLS), .NodeW(NodeW)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .res_valid_o(valid_o), .res_o(out_o)
  );

  // a pop needs queued data
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // busy implies the queue holds data
  a_busy_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> q_valid) else $error("busy with empty queue");

  // busy holds until the back end pops
  a_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !q_pop) |=> busy) else $error("queue lost an entry");

endmodule
